### rtl/core/triangle_tangent_basis_defines.svh
// Assertion macros shared by tbn_divider.sv and triangle_tangent_basis.sv.
`ifndef TRIANGLE_TANGENT_BASIS_DEFINES_SVH
`define TRIANGLE_TANGENT_BASIS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TBN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbn assertion failed");

// Next-cycle implication, disabled during reset.
`define TBN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbn assertion failed");

`endif

### rtl/core/tbn_pkg.sv
package tbn_pkg;

	localparam int POS_W      = 16;
	localparam int UV_W       = 16;
	localparam int OUT_W      = 32;
	localparam int POS_FRAC   = POS_W / 2;
	localparam int UV_FRAC    = UV_W - 4;
	localparam int OUT_FRAC   = OUT_W / 2;
	localparam int QUOT_SHIFT = OUT_FRAC + UV_FRAC - POS_FRAC;
	localparam int OVF_SH     = OUT_W - QUOT_SHIFT;

	localparam int EDGE_W = POS_W + 1;
	localparam int UVE_W  = UV_W + 1;
	localparam int MOP_W  = (EDGE_W > UVE_W) ? EDGE_W : UVE_W;
	localparam int PROD_W = 2 * MOP_W;
	localparam int NUM_W  = PROD_W + 1;
	localparam int CNT_W  = $clog2(OUT_W);

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [NUM_W-1:0] den;
	} tbn_div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [OUT_W-1:0] quot;
	} tbn_div_rsp_t;

endpackage

### rtl/core/tbn_vtx_if.sv
interface tbn_vtx_if import tbn_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic signed [UV_W-1:0]  tex_u;
	logic signed [UV_W-1:0]  tex_v;

	modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

### rtl/core/tbn_res_if.sv
interface tbn_res_if import tbn_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] tangent_x;
	logic signed [OUT_W-1:0] tangent_y;
	logic signed [OUT_W-1:0] tangent_z;
	logic signed [OUT_W-1:0] bitangent_x;
	logic signed [OUT_W-1:0] bitangent_y;
	logic signed [OUT_W-1:0] bitangent_z;
	logic                    degenerate;

	modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
		bitangent_y, bitangent_z, degenerate, input ready);
	modport sink (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
		bitangent_y, bitangent_z, degenerate, output ready);
endinterface

### rtl/core/tbn_divider.sv
`include "triangle_tangent_basis_defines.svh"

module tbn_divider import tbn_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  tbn_div_req_t req,
	output tbn_div_rsp_t rsp
);

	logic             busy_q;
	logic             fin_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] ad_q;
	logic [OUT_W-1:0] low_q;
	logic [OUT_W-1:0] q_q;
	logic             neg_q;
	logic             ovf_q;
	logic             done_q;
	logic signed [OUT_W-1:0] quot_q;

	logic [NUM_W-1:0] an;
	logic [NUM_W-1:0] ad;
	logic             ovf;
	logic [NUM_W:0]   trial;
	logic             take;
	logic [NUM_W:0]   rem2;
	logic             rnd;
	logic [OUT_W:0]   qr;
	logic [OUT_W:0]   lim;
	logic [OUT_W:0]   mag;

	always_comb begin
		an = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
		ad = req.den[NUM_W-1] ? NUM_W'(-req.den) : NUM_W'(req.den);
		// The quotient cannot fit the output when |num| >= |den| * 2^OVF_SH.
		ovf = {{OVF_SH{1'b0}}, an} >= {ad, {OVF_SH{1'b0}}};
		trial = {rem_q, low_q[OUT_W-1]};
		take = trial >= {1'b0, ad_q};
		rem2 = {rem_q, 1'b0};
		rnd = rem2 >= {1'b0, ad_q};
		qr = {1'b0, q_q} + (OUT_W+1)'(rnd);
		lim = neg_q ? ((OUT_W+1)'(1) << (OUT_W-1)) : (((OUT_W+1)'(1) << (OUT_W-1)) - 1'b1);
		mag = (ovf_q || qr > lim) ? lim : qr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(OUT_W-1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[NUM_W-1] ^ req.den[NUM_W-1];
			ovf_q <= ovf;
			ad_q  <= ad;
			rem_q <= an >> OVF_SH;
			low_q <= {an[OVF_SH-1:0], {QUOT_SHIFT{1'b0}}};
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= take ? NUM_W'(trial - {1'b0, ad_q}) : NUM_W'(trial);
			low_q <= {low_q[OUT_W-2:0], 1'b0};
			q_q   <= {q_q[OUT_W-2:0], take};
		end
		if (fin_q) begin
			quot_q <= neg_q ? OUT_W'(-mag) : OUT_W'(mag);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	`TBN_ASSERT_NOW(a_no_start_busy, req.start, !busy_q && !fin_q)
	`TBN_ASSERT_NEXT(a_done_pulse, done_q, !done_q)
	`TBN_ASSERT_NEXT(a_start_runs, req.start, busy_q)

endmodule

### rtl/core/triangle_tangent_basis.sv
// Tangent and bitangent of textured triangles.
// Channel vtx carries vertices (position Q8.8, texture coordinate Q4.12);
// every three accepted transactions form one triangle. Channel res carries
// one result per triangle: tangent and bitangent in Q16.16, saturated, plus
// a degenerate flag that is set, with zero vectors, when the UV determinant
// is zero.
// The first two corners are taken in one cycle each. The third corner starts
// the computation: one shared multiplier forms the determinant and then each
// of the six numerators from two products, taken one at a time (S_MUL1,
// S_MUL2) and subtracted (S_SUB), and a bit-serial divider divides each
// numerator by the determinant. A full triangle raises res.valid after the
// sixth quotient is stored; a degenerate one skips the divisions. vtx.ready
// is low while this runs, until the result moves to the output register.
// The result sits in an output register; if the receiver stalls, the block
// still takes and computes the next triangle; a finished one waits until the
// register is free. Reset clears the held corner count and the output valid.
`include "triangle_tangent_basis_defines.svh"

module triangle_tangent_basis import tbn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tbn_vtx_if.sink   vtx,
	tbn_res_if.source res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL1 = 3'd1;
	localparam logic [2:0] S_MUL2 = 3'd2;
	localparam logic [2:0] S_SUB  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] k_q;
	logic [1:0] cnt_q;

	logic signed [POS_W-1:0] cpos_q [2][3];
	logic signed [UV_W-1:0]  cuv_q  [2][2];
	logic signed [EDGE_W-1:0] dp1_q [3];
	logic signed [EDGE_W-1:0] dp2_q [3];
	logic signed [UVE_W-1:0]  du1_q, dv1_q, du2_q, dv2_q;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [NUM_W-1:0]  acc_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [NUM_W-1:0]  det_q;
	logic                     start_q;
	logic signed [OUT_W-1:0]  vec_q [6];
	logic                     deg_q;

	logic                    ov_q;
	logic signed [OUT_W-1:0] ovec_q [6];
	logic                    odeg_q;

	logic signed [POS_W-1:0] p_in [3];
	logic signed [MOP_W-1:0] a1, b1, a2, b2, opa, opb;
	logic signed [NUM_W-1:0] diff;
	logic                    accept;
	logic                    out_free;
	logic [1:0]              j;

	tbn_div_req_t div_req;
	tbn_div_rsp_t div_rsp;

	assign vtx.ready = (state_q == S_IDLE);
	assign accept    = vtx.valid && vtx.ready;
	assign out_free  = !ov_q || res.ready;

	assign p_in[0] = vtx.pos_x;
	assign p_in[1] = vtx.pos_y;
	assign p_in[2] = vtx.pos_z;

	// Component k: 0 is the determinant, 1..3 tangent x/y/z, 4..6 bitangent x/y/z.
	always_comb begin
		j  = 2'd0;
		a1 = MOP_W'(du1_q);
		b1 = MOP_W'(dv2_q);
		a2 = MOP_W'(dv1_q);
		b2 = MOP_W'(du2_q);
		case (k_q) inside
			[3'd1:3'd3]: begin
				j  = 2'(k_q - 3'd1);
				a1 = MOP_W'(dp1_q[j]);
				b1 = MOP_W'(dv2_q);
				a2 = MOP_W'(dp2_q[j]);
				b2 = MOP_W'(dv1_q);
			end
			[3'd4:3'd6]: begin
				j  = 2'(k_q - 3'd4);
				a1 = MOP_W'(dp2_q[j]);
				b1 = MOP_W'(du1_q);
				a2 = MOP_W'(dp1_q[j]);
				b2 = MOP_W'(du2_q);
			end
			default: ;
		endcase
		opa  = (state_q == S_MUL1) ? a1 : a2;
		opb  = (state_q == S_MUL1) ? b1 : b2;
		diff = acc_q - NUM_W'(prod_q);
	end

	assign div_req.start = start_q;
	assign div_req.num   = num_q;
	assign div_req.den   = det_q;

	tbn_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			cnt_q   <= '0;
			start_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (state_q == S_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (ov_q && res.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cnt_q == 2'd2) begin
							cnt_q   <= '0;
							k_q     <= '0;
							state_q <= S_MUL1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SUB;
				S_SUB: begin
					if (k_q == 3'd0) begin
						if (diff == '0) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= 3'd1;
							state_q <= S_MUL1;
						end
					end else begin
						start_q <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (k_q == 3'd6) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_MUL1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (cnt_q != 2'd2) begin
				for (int i = 0; i < 3; i++) begin
					cpos_q[cnt_q[0]][i] <= p_in[i];
				end
				cuv_q[cnt_q[0]][0] <= vtx.tex_u;
				cuv_q[cnt_q[0]][1] <= vtx.tex_v;
			end else begin
				for (int i = 0; i < 3; i++) begin
					dp1_q[i] <= EDGE_W'(cpos_q[1][i]) - EDGE_W'(cpos_q[0][i]);
					dp2_q[i] <= EDGE_W'(p_in[i]) - EDGE_W'(cpos_q[0][i]);
				end
				du1_q <= UVE_W'(cuv_q[1][0]) - UVE_W'(cuv_q[0][0]);
				dv1_q <= UVE_W'(cuv_q[1][1]) - UVE_W'(cuv_q[0][1]);
				du2_q <= UVE_W'(vtx.tex_u) - UVE_W'(cuv_q[0][0]);
				dv2_q <= UVE_W'(vtx.tex_v) - UVE_W'(cuv_q[0][1]);
			end
		end
		if (state_q == S_MUL1 || state_q == S_MUL2) begin
			prod_q <= opa * opb;
		end
		if (state_q == S_MUL2) begin
			acc_q <= NUM_W'(prod_q);
		end
		if (state_q == S_SUB) begin
			if (k_q == 3'd0) begin
				det_q <= diff;
				deg_q <= (diff == '0);
				if (diff == '0) begin
					for (int i = 0; i < 6; i++) begin
						vec_q[i] <= '0;
					end
				end
			end else begin
				num_q <= diff;
			end
		end
		if (state_q == S_DIV && div_rsp.done) begin
			vec_q[k_q - 3'd1] <= div_rsp.quot;
		end
		if (state_q == S_DONE && out_free) begin
			ovec_q <= vec_q;
			odeg_q <= deg_q;
		end
	end

	assign res.valid       = ov_q;
	assign res.tangent_x   = ovec_q[0];
	assign res.tangent_y   = ovec_q[1];
	assign res.tangent_z   = ovec_q[2];
	assign res.bitangent_x = ovec_q[3];
	assign res.bitangent_y = ovec_q[4];
	assign res.bitangent_z = ovec_q[5];
	assign res.degenerate  = odeg_q;

	`TBN_ASSERT_NEXT(a_third_starts, accept && cnt_q == 2'd2, state_q == S_MUL1)
	`TBN_ASSERT_NOW(a_deg_zero, ov_q && odeg_q, ovec_q[0] == '0 && ovec_q[5] == '0)
	`TBN_ASSERT_NOW(a_div_in_div, div_rsp.done, state_q == S_DIV)

endmodule
